// ===== rtl/rab_pkg.sv =====
// ----------------------------------------------------------------------------
// rab_pkg
// Shared types, widths and helpers for the rectangle alpha blit.
// ----------------------------------------------------------------------------
package rab_pkg;

	localparam int MAX_DIM    = 4096;
	localparam int CNT_W      = $clog2(MAX_DIM);
	localparam int ORG_W      = 12;
	localparam int DIM_W      = 13;
	localparam int POS_W      = ((CNT_W > ORG_W) ? CNT_W : ORG_W) + 1;
	localparam int IDX_W      = 24;
	localparam int PIX_W      = 32;
	localparam int LANE_W     = 8;
	localparam int SEL_W      = 2;
	localparam int ORDER_W    = 8;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 13;
	localparam int FIFO_DEPTH = 4;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

	localparam logic [LANE_W-1:0]  LANE_MAX      = 8'hFF;
	localparam logic [ORDER_W-1:0] ORDER_DEFAULT = 8'd228;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_ORIGIN_X,
		CFG_ORIGIN_Y,
		CFG_STRIDE,
		CFG_WIDTH,
		CFG_HEIGHT,
		CFG_BLEND,
		CFG_ORDER
	} rab_cfg_idx_t;

	typedef struct packed {
		logic [ORG_W-1:0]   dest_origin_x;
		logic [ORG_W-1:0]   dest_origin_y;
		logic [DIM_W-1:0]   dest_stride;
		logic [DIM_W-1:0]   rect_width;
		logic [DIM_W-1:0]   rect_height;
		logic               blend_enable;
		logic [ORDER_W-1:0] channel_order;
	} rab_cfg_t;

	// One classified item between front and back.
	typedef struct packed {
		logic [IDX_W-1:0]  index;
		logic [PIX_W-1:0]  src;
		logic [PIX_W-1:0]  word;
		logic [LANE_W-1:0] alpha;
		logic              last;
		logic              blend;
	} rab_entry_t;

	// Clamp a size register to 1..MAX_DIM.
	function automatic logic [CNT_W:0] eff_dim(input logic [DIM_W-1:0] v);
		logic [31:0] vx;
		vx = 32'(v);
		if (vx == 32'd0)
			return (CNT_W+1)'(1);
		if (vx > 32'(MAX_DIM))
			return (CNT_W+1)'(MAX_DIM);
		return (CNT_W+1)'(vx);
	endfunction

	function automatic logic [LANE_W-1:0] get_lane(input logic [PIX_W-1:0] w,
		input logic [SEL_W-1:0] sel);
		return w[sel*LANE_W +: LANE_W];
	endfunction

	function automatic logic [PIX_W-1:0] set_lane(input logic [PIX_W-1:0] w,
		input logic [SEL_W-1:0] sel, input logic [LANE_W-1:0] v);
		logic [PIX_W-1:0] r;
		r = w;
		r[sel*LANE_W +: LANE_W] = v;
		return r;
	endfunction

endpackage

// ===== rtl/rab_if.sv =====
// ----------------------------------------------------------------------------
// rab_if
// Valid/ready channels of the rectangle alpha blit: pixel in, pixel out,
// configuration write.
// ----------------------------------------------------------------------------
interface rab_in_if;
	import rab_pkg::*;
	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] src_pixel;
	logic [PIX_W-1:0] dst_pixel;

	modport source (output valid, output src_pixel, output dst_pixel, input ready);
	modport sink   (input valid, input src_pixel, input dst_pixel, output ready);
endinterface

interface rab_out_if;
	import rab_pkg::*;
	logic             valid;
	logic             ready;
	logic [IDX_W-1:0] dest_index;
	logic [PIX_W-1:0] pixel_out;
	logic             last_pixel;

	modport source (output valid, output dest_index, output pixel_out,
		output last_pixel, input ready);
	modport sink   (input valid, input dest_index, input pixel_out,
		input last_pixel, output ready);
endinterface

interface rab_cfg_if;
	import rab_pkg::*;
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== rtl/rect_alpha_blit.sv =====
// ----------------------------------------------------------------------------
// rect_alpha_blit
// Rectangle blit write-back stage: raster position, destination index and
// optional source-over alpha blend of the red, green and blue lanes.
// ----------------------------------------------------------------------------
//  channel   role    payload
//  cfg       sink    index[2:0], data[12:0]  (register write, always ready)
//  pix_in    sink    src_pixel[31:0], dst_pixel[31:0]
//  pix_out   source  dest_index[23:0], pixel_out[31:0], last_pixel
//
//  One item per cycle while the queue is not full; the result passes two front stages
//  (row times stride multiply), the queue and three lane stages.
//  A four-entry queue lets the front keep taking items while the output stalls.
//  Reset clears the raster counters and loads the register defaults.
//  pix_in.ready drops only when the queue is full and the front holds an item.
// ----------------------------------------------------------------------------
module rect_alpha_blit (
	input  logic      clk,
	input  logic      arst_n,
	rab_cfg_if.sink   cfg,
	rab_in_if.sink    pix_in,
	rab_out_if.source pix_out
);
	import rab_pkg::*;

	rab_cfg_t   cfg_q;
	rab_entry_t wr_data, rd_data;
	logic       push, full, pop, empty;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.dest_origin_x <= '0;
			cfg_q.dest_origin_y <= '0;
			cfg_q.dest_stride   <= DIM_W'(1);
			cfg_q.rect_width    <= DIM_W'(1);
			cfg_q.rect_height   <= DIM_W'(1);
			cfg_q.blend_enable  <= 1'b0;
			cfg_q.channel_order <= ORDER_DEFAULT;
		end else if (cfg.valid) begin
			unique case (rab_cfg_idx_t'(cfg.index))
				CFG_ORIGIN_X: cfg_q.dest_origin_x <= cfg.data[ORG_W-1:0];
				CFG_ORIGIN_Y: cfg_q.dest_origin_y <= cfg.data[ORG_W-1:0];
				CFG_STRIDE:   cfg_q.dest_stride   <= cfg.data[DIM_W-1:0];
				CFG_WIDTH:    cfg_q.rect_width    <= cfg.data[DIM_W-1:0];
				CFG_HEIGHT:   cfg_q.rect_height   <= cfg.data[DIM_W-1:0];
				CFG_BLEND:    cfg_q.blend_enable  <= cfg.data[0];
				CFG_ORDER:    cfg_q.channel_order <= cfg.data[ORDER_W-1:0];
				default: begin
				end
			endcase
		end
	end

	rab_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg_q  (cfg_q),
		.pix_in (pix_in),
		.full   (full),
		.push   (push),
		.entry  (wr_data)
	);

	rab_fifo u_fifo (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_data (wr_data),
		.full    (full),
		.pop     (pop),
		.rd_data (rd_data),
		.empty   (empty)
	);

	rab_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_q   (cfg_q),
		.rd_data (rd_data),
		.empty   (empty),
		.pop     (pop),
		.pix_out (pix_out)
	);

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full))
		else $error("queue written while full");

	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

	a_stall_holds_queue: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_out.valid && !pix_out.ready) |-> !pop)
		else $error("queue drained during output stall");

endmodule

// ===== rtl/rab_front.sv =====
// ----------------------------------------------------------------------------
// rab_front
// Accepts pixel items, tracks the raster position, forms the destination
// index and last flag, and classifies each item as blend or copy.
// ----------------------------------------------------------------------------
module rab_front (
	input  logic                clk,
	input  logic                arst_n,
	input  rab_pkg::rab_cfg_t   cfg_q,
	rab_in_if.sink              pix_in,
	input  logic                full,
	output logic                push,
	output rab_pkg::rab_entry_t entry
);
	import rab_pkg::*;

	logic [CNT_W-1:0]         col_cnt_q, row_cnt_q;
	logic [CNT_W:0]           w_eff, h_eff, col_inc, row_inc;
	logic                     row_end, rect_end, accept, adv;

	logic                     v_s1;
	logic [POS_W-1:0]         row_s1, col_s1;
	logic                     last_s1;
	logic [PIX_W-1:0]         src_s1, dst_s1;
	logic                     blend_s1;

	logic                     v_s2;
	logic [IDX_W-1:0]         prod_s2;
	logic [POS_W-1:0]         col_s2;
	logic                     last_s2;
	logic [PIX_W-1:0]         src_s2, dst_s2;
	logic                     blend_s2;

	logic [POS_W+DIM_W-1:0]   prod_full;

	// hold the whole front while the queue cannot take the oldest item
	assign adv          = !(v_s2 && full);
	assign pix_in.ready = adv;
	assign accept       = pix_in.valid && adv;

	always_comb begin
		w_eff    = eff_dim(cfg_q.rect_width);
		h_eff    = eff_dim(cfg_q.rect_height);
		col_inc  = {1'b0, col_cnt_q} + 1'b1;
		row_inc  = {1'b0, row_cnt_q} + 1'b1;
		row_end  = col_inc >= w_eff;
		rect_end = row_end && (row_inc >= h_eff);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_cnt_q <= '0;
			row_cnt_q <= '0;
		end else if (accept) begin
			if (row_end) begin
				col_cnt_q <= '0;
				row_cnt_q <= rect_end ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_cnt_q <= col_inc[CNT_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= accept;
			v_s2 <= v_s1;
		end
	end

	assign prod_full = row_s1 * cfg_q.dest_stride;

	always_ff @(posedge clk) begin
		if (adv) begin
			row_s1   <= POS_W'(row_cnt_q) + POS_W'(cfg_q.dest_origin_y);
			col_s1   <= POS_W'(col_cnt_q) + POS_W'(cfg_q.dest_origin_x);
			last_s1  <= rect_end;
			src_s1   <= pix_in.src_pixel;
			dst_s1   <= pix_in.dst_pixel;
			blend_s1 <= cfg_q.blend_enable;

			prod_s2  <= prod_full[IDX_W-1:0];
			col_s2   <= col_s1;
			last_s2  <= last_s1;
			src_s2   <= src_s1;
			dst_s2   <= dst_s1;
			blend_s2 <= blend_s1;
		end
	end

	assign push = v_s2 && !full;

	always_comb begin
		entry.index = prod_s2 + IDX_W'(col_s2);
		entry.src   = src_s2;
		entry.word  = blend_s2 ? dst_s2 : src_s2;
		entry.alpha = get_lane(src_s2, cfg_q.channel_order[7:6]);
		entry.last  = last_s2;
		entry.blend = blend_s2;
	end

endmodule

// ===== rtl/rab_fifo.sv =====
// ----------------------------------------------------------------------------
// rab_fifo
// Short register queue that decouples the front from the back.
// ----------------------------------------------------------------------------
module rab_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	input  rab_pkg::rab_entry_t wr_data,
	output logic                full,
	input  logic                pop,
	output rab_pkg::rab_entry_t rd_data,
	output logic                empty
);
	import rab_pkg::*;

	rab_entry_t          mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0]  wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]    count_q;

	assign full    = count_q == (FIFO_AW+1)'(FIFO_DEPTH);
	assign empty   = count_q == '0;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == FIFO_AW'(FIFO_DEPTH-1)) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= wr_data;
	end

endmodule

// ===== rtl/rab_back.sv =====
// ----------------------------------------------------------------------------
// rab_back
// Blends red, green and blue one lane per stage and presents the result
// in the output register.
// ----------------------------------------------------------------------------
module rab_back (
	input  logic                clk,
	input  logic                arst_n,
	input  rab_pkg::rab_cfg_t   cfg_q,
	input  rab_pkg::rab_entry_t rd_data,
	input  logic                empty,
	output logic                pop,
	rab_out_if.source           pix_out
);
	import rab_pkg::*;

	logic       adv;
	logic       v_s1, v_s2, v_s3;
	rab_entry_t e_s1, e_s2, e_s3;

	// (255-a)*d + a*s, divided by 255 as (x + (x >> 8) + 1) >> 8
	function automatic rab_entry_t mix_lane(input rab_entry_t t,
		input logic [SEL_W-1:0] sel);
		logic [LANE_W-1:0] d, s, na;
		logic [2*LANE_W-1:0] p0, p1, x, y;
		rab_entry_t r;
		r  = t;
		d  = get_lane(t.word, sel);
		s  = get_lane(t.src, sel);
		na = LANE_MAX - t.alpha;
		p0 = na * d;
		p1 = t.alpha * s;
		x  = p0 + p1;
		y  = x + (2*LANE_W)'(x[2*LANE_W-1:LANE_W]) + 1'b1;
		if (t.blend)
			r.word = set_lane(t.word, sel, y[2*LANE_W-1:LANE_W]);
		return r;
	endfunction

	assign adv = !v_s3 || pix_out.ready;
	assign pop = adv && !empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !empty;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			e_s1 <= mix_lane(rd_data, cfg_q.channel_order[1:0]);
			e_s2 <= mix_lane(e_s1, cfg_q.channel_order[3:2]);
			e_s3 <= mix_lane(e_s2, cfg_q.channel_order[5:4]);
		end
	end

	assign pix_out.valid      = v_s3;
	assign pix_out.dest_index = e_s3.index;
	assign pix_out.pixel_out  = e_s3.word;
	assign pix_out.last_pixel = e_s3.last;

endmodule

// ===== tb/rect_alpha_blit_checker.sv =====
// ----------------------------------------------------------------------------
// rect_alpha_blit_checker
// Watches the configuration, pixel-in and pixel-out channels of the blit
// stage. It keeps its own copy of the registers and of the raster position,
// works out the destination index, the blended or copied word and the
// last-pixel flag of every pixel taken in, and compares each write-back
// against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module rect_alpha_blit_checker (
	input  logic clk,
	input  logic arst_n,
	rab_cfg_if   cfg,
	rab_in_if    pix_in,
	rab_out_if   pix_out,
	output int   pending,
	output int   failures
);
	import rab_pkg::*;

	localparam int unsigned LANE_FULL = 255;

	typedef struct packed {
		logic [IDX_W-1:0] index;
		logic [PIX_W-1:0] word;
		logic             last;
	} blit_write_t;

	rab_cfg_t    regs;
	int unsigned column_pos;
	int unsigned row_pos;
	blit_write_t pending_writes[$];
	int          mismatches = 0;

	function automatic int unsigned clamp_dim(input logic [DIM_W-1:0] v);
		if (v == '0)
			return 1;
		if (v > MAX_DIM)
			return MAX_DIM;
		return v;
	endfunction

	always @(posedge clk or negedge arst_n) begin : track
		logic [LANE_W-1:0] src_lane [4];
		logic [LANE_W-1:0] dst_lane [4];
		int unsigned       w, h, col, row, flat, alpha, lane, mix;
		logic              row_end;
		blit_write_t       exp_w;
		if (!arst_n) begin
			regs.dest_origin_x = '0;
			regs.dest_origin_y = '0;
			regs.dest_stride   = 1;
			regs.rect_width    = 1;
			regs.rect_height   = 1;
			regs.blend_enable  = 1'b0;
			regs.channel_order = ORDER_DEFAULT;
			column_pos = 0;
			row_pos    = 0;
			pending_writes.delete();
			pending <= 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				case (cfg.index)
					CFG_ORIGIN_X: regs.dest_origin_x = cfg.data[ORG_W-1:0];
					CFG_ORIGIN_Y: regs.dest_origin_y = cfg.data[ORG_W-1:0];
					CFG_STRIDE:   regs.dest_stride   = cfg.data[DIM_W-1:0];
					CFG_WIDTH:    regs.rect_width    = cfg.data[DIM_W-1:0];
					CFG_HEIGHT:   regs.rect_height   = cfg.data[DIM_W-1:0];
					CFG_BLEND:    regs.blend_enable  = cfg.data[0];
					CFG_ORDER:    regs.channel_order = cfg.data[ORDER_W-1:0];
					default: ;
				endcase
			end

			if (pix_out.valid && pix_out.ready) begin
				if (pending_writes.size() == 0) begin
					$display("%0t: write-back, expected none, actual index %h word %h last %b",
						$time, pix_out.dest_index, pix_out.pixel_out, pix_out.last_pixel);
					mismatches++;
				end else begin
					exp_w = pending_writes.pop_front();
					if (pix_out.dest_index !== exp_w.index) begin
						$display("%0t: dest_index expected %h actual %h",
							$time, exp_w.index, pix_out.dest_index);
						mismatches++;
					end
					if (pix_out.pixel_out !== exp_w.word) begin
						$display("%0t: pixel_out expected %h actual %h",
							$time, exp_w.word, pix_out.pixel_out);
						mismatches++;
					end
					if (pix_out.last_pixel !== exp_w.last) begin
						$display("%0t: last_pixel expected %b actual %b",
							$time, exp_w.last, pix_out.last_pixel);
						mismatches++;
					end
				end
			end

			if (pix_in.valid && pix_in.ready) begin
				w = clamp_dim(regs.rect_width);
				h = clamp_dim(regs.rect_height);
				col  = column_pos + regs.dest_origin_x;
				row  = row_pos + regs.dest_origin_y;
				flat = row * regs.dest_stride + col;
				row_end = (column_pos + 1) >= w;
				exp_w.index = flat[IDX_W-1:0];
				exp_w.last  = row_end && ((row_pos + 1) >= h);
				if (regs.blend_enable) begin
					for (int k = 0; k < 4; k++) begin
						src_lane[k] = pix_in.src_pixel[k*LANE_W +: LANE_W];
						dst_lane[k] = pix_in.dst_pixel[k*LANE_W +: LANE_W];
					end
					// alpha always comes from the untouched source word
					alpha = src_lane[regs.channel_order[ORDER_W-1 -: SEL_W]];
					// red, green, blue in turn; a shared lane sees the previous update
					for (int k = 0; k < 3; k++) begin
						lane = regs.channel_order[k*SEL_W +: SEL_W];
						mix  = ((LANE_FULL - alpha) * dst_lane[lane] + alpha * src_lane[lane])
							/ LANE_FULL;
						dst_lane[lane] = mix[LANE_W-1:0];
					end
					exp_w.word = {dst_lane[3], dst_lane[2], dst_lane[1], dst_lane[0]};
				end else begin
					exp_w.word = pix_in.src_pixel;
				end
				pending_writes.push_back(exp_w);

				// advance the raster; a position past a shrunk size wraps here
				if (row_end) begin
					column_pos = 0;
					row_pos = ((row_pos + 1) >= h) ? 0 : row_pos + 1;
				end else begin
					column_pos++;
				end
			end
			pending <= pending_writes.size();
		end
		failures <= mismatches;
	end

endmodule

// ===== tb/rect_alpha_blit_tb.sv =====
// ----------------------------------------------------------------------------
// rect_alpha_blit_tb
// Drives the blit stage with a directed set of rectangles (default registers,
// blend extremes, shared lanes, zero and oversize dimensions, index wrap,
// geometry change mid-rectangle), then random rectangles under random source
// and sink idling, one long sink stall included. A side checker predicts and
// compares every write-back; a watchdog ends a run that stops moving.
// ----------------------------------------------------------------------------
module rect_alpha_blit_tb;
	import rab_pkg::*;

	localparam int RANDOM_ITEMS   = 630;
	localparam int OVERSIZE_ITEMS = 24;
	localparam int GAP_MAX        = 8;
	localparam int HOLD_CYCLES    = 300;
	localparam int SETTLE_CYCLES  = 12;
	localparam int WATCHDOG_LIMIT = 5000;

	localparam logic [CFG_IDX_W-1:0]  CFG_SPARE = 3'd7;
	localparam logic [CFG_DATA_W-1:0] DATA_ALL  = '1;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;
	bit   no_idle  = 1'b0;
	bit   hold_out = 1'b0;
	int   idle_cycles = 0;
	int   random_sent = 0;
	int   pending;
	int   failures;

	rab_cfg_if cfg_ch ();
	rab_in_if  pix_in_ch ();
	rab_out_if pix_out_ch ();

	rect_alpha_blit uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_ch),
		.pix_in  (pix_in_ch),
		.pix_out (pix_out_ch)
	);

	rect_alpha_blit_checker write_back_check (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_ch),
		.pix_in   (pix_in_ch),
		.pix_out  (pix_out_ch),
		.pending  (pending),
		.failures (failures)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		if (!arst_n || (cfg_ch.valid && cfg_ch.ready) || (pix_in_ch.valid && pix_in_ch.ready)
			|| (pix_out_ch.valid && pix_out_ch.ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
		input logic [CFG_DATA_W-1:0] val);
		cfg_ch.index <= idx;
		cfg_ch.data  <= val;
		cfg_ch.valid <= 1'b1;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_blit(input logic [CFG_DATA_W-1:0] ox, oy, stride, w, h,
		input logic blend, input logic [ORDER_W-1:0] order);
		write_reg(CFG_ORIGIN_X, ox);
		write_reg(CFG_ORIGIN_Y, oy);
		write_reg(CFG_STRIDE, stride);
		write_reg(CFG_WIDTH, w);
		write_reg(CFG_HEIGHT, h);
		write_reg(CFG_BLEND, blend);
		write_reg(CFG_ORDER, order);
	endtask

	// lanes lean toward 0x00 and 0xFF so that alpha extremes come up often
	function automatic logic [PIX_W-1:0] rand_pixel();
		logic [PIX_W-1:0] p;
		for (int k = 0; k < 4; k++) begin
			case ($urandom_range(0, 3))
				0:       p[k*LANE_W +: LANE_W] = '0;
				1:       p[k*LANE_W +: LANE_W] = LANE_MAX;
				default: p[k*LANE_W +: LANE_W] = LANE_W'($urandom());
			endcase
		end
		return p;
	endfunction

	// valid stays high across back-to-back items; drop it only for a gap
	task automatic send_pixel(input logic [PIX_W-1:0] s, d);
		int gap;
		gap = no_idle ? 0 : $urandom_range(0, GAP_MAX);
		if (gap > 0) begin
			pix_in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		pix_in_ch.valid     <= 1'b1;
		pix_in_ch.src_pixel <= s;
		pix_in_ch.dst_pixel <= d;
		@(posedge clk);
		while (!pix_in_ch.ready) @(posedge clk);
	endtask

	task automatic send_random(input int count);
		repeat (count) send_pixel(rand_pixel(), rand_pixel());
	endtask

	task automatic drain();
		pix_in_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : result_sink
		int gap;
		pix_out_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_out) begin
				hold_out = 1'b0;
				gap = HOLD_CYCLES;
			end else if (no_idle) begin
				gap = 0;
			end else begin
				gap = $urandom_range(0, GAP_MAX);
			end
			if (gap > 0) begin
				pix_out_ch.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			pix_out_ch.ready <= 1'b1;
			@(posedge clk);
			while (!pix_out_ch.valid) @(posedge clk);
		end
	end

	initial begin : stimulus
		logic [CFG_DATA_W-1:0] stride, w, h;
		int n;
		cfg_ch.valid        <= 1'b0;
		cfg_ch.index        <= '0;
		cfg_ch.data         <= '0;
		pix_in_ch.valid     <= 1'b0;
		pix_in_ch.src_pixel <= '0;
		pix_in_ch.dst_pixel <= '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// registers at their reset values: plain copy, one-pixel rectangle
		send_pixel('0, '1);
		send_pixel('1, '0);
		drain();

		// blend with the default lane order over a 3x2 rectangle
		write_reg(CFG_BLEND, 1);
		write_reg(CFG_WIDTH, 3);
		write_reg(CFG_HEIGHT, 2);
		write_reg(CFG_STRIDE, 5);
		write_reg(CFG_ORIGIN_X, 2);
		write_reg(CFG_ORIGIN_Y, 1);
		send_pixel(32'h00FFFFFF, 32'h12345678);
		send_pixel(32'hFF123456, 32'hFFFFFFFF);
		send_pixel(32'h80FF00FF, 32'h4400FF00);
		send_pixel(32'hFF000000, 32'h00FFFFFF);
		send_pixel(32'h7F7F7F7F, 32'h01010101);
		send_pixel(32'h01FFFFFF, 32'hFE000000);
		drain();

		// shared lanes: all colors and alpha on lane 0
		write_reg(CFG_ORDER, 0);
		write_reg(CFG_WIDTH, 2);
		write_reg(CFG_HEIGHT, 1);
		send_pixel(32'h000000C0, 32'h00000040);
		send_pixel(32'h00000080, 32'hFFFFFFFF);
		drain();

		// red and green on one lane; then a permuted order with alpha on lane 1
		write_reg(CFG_ORDER, 13'h0E5);
		send_pixel(32'h80402010, 32'h10203040);
		drain();
		write_reg(CFG_ORDER, 13'h04E);
		send_pixel(32'h11C02233, 32'hA0B0C0D0);
		drain();

		// zero sizes act as one; the unused index changes nothing
		write_reg(CFG_WIDTH, 0);
		write_reg(CFG_HEIGHT, 0);
		write_reg(CFG_SPARE, DATA_ALL);
		send_random(2);
		drain();

		// index past 24 bits wraps; then a zero stride
		set_blit(DATA_ALL, 13'd4095, DATA_ALL, 2, 2, 1'b1, ORDER_DEFAULT);
		send_random(4);
		drain();
		write_reg(CFG_STRIDE, 0);
		send_random(2);
		drain();

		// shrink the width in the middle of a rectangle
		set_blit(0, 0, 16, 5, 3, 1'b0, ORDER_DEFAULT);
		send_random(3);
		drain();
		write_reg(CFG_WIDTH, 2);
		send_random(2);
		drain();

		// oversize width, then oversize height
		set_blit(0, 0, DATA_ALL, DATA_ALL, 1, 1'b1, 8'hE4);
		send_random(OVERSIZE_ITEMS);
		drain();
		write_reg(CFG_WIDTH, 1);
		write_reg(CFG_HEIGHT, CFG_DATA_W'(MAX_DIM + 1));
		no_idle = 1'b1;
		send_random(OVERSIZE_ITEMS);
		drain();

		while (random_sent < RANDOM_ITEMS) begin
			case ($urandom_range(0, 3))
				0:       stride = 0;
				1:       stride = DATA_ALL;
				2:       stride = CFG_DATA_W'(MAX_DIM);
				default: stride = CFG_DATA_W'($urandom_range(1, 64));
			endcase
			case ($urandom_range(0, 7))
				0:       w = 0;
				1:       w = CFG_DATA_W'($urandom_range(MAX_DIM + 1, 8191));
				default: w = CFG_DATA_W'($urandom_range(1, 8));
			endcase
			h = CFG_DATA_W'($urandom_range(0, 6));
			set_blit(CFG_DATA_W'($urandom_range(0, 8191)), CFG_DATA_W'($urandom_range(0, 8191)),
				stride, w, h, 1'($urandom_range(0, 1)), ORDER_W'($urandom_range(0, 255)));
			// sometimes a whole multiple of the rectangle's pixel count, otherwise a random count
			if (w != 0 && w <= 8 && $urandom_range(0, 1))
				n = w * ((h == 0) ? 1 : h) * $urandom_range(1, 3);
			else
				n = $urandom_range(1, 60);
			no_idle = ($urandom_range(0, 4) == 0);
			if (random_sent == 0) begin
				// stall the sink while items keep coming so the input backs up
				hold_out = 1'b1;
				no_idle  = 1'b1;
				n = 40;
			end
			send_random(n);
			random_sent += n;
			drain();
		end

		if (failures == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
